[hw/rtl/http_chunked_body_decoder_macros.svh]
// Assertion macros for the chunked body decoder.
// Each macro uses the clk and arst_n of the module that expands it.
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HCBD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hcbd same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HCBD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hcbd next-cycle check failed");

`endif

[hw/rtl/hcbd_pkg.sv]
// Shared types, codes and helpers for the chunked body decoder.
// No dependencies; used by every RTL file of the block.
`default_nettype none

package hcbd_pkg;

	localparam int COUNT_WIDTH_DEF = 32;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CHUNK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LINE  = 1'd1;

	localparam logic [31:0] MAX_CHUNK_RST = 32'h0100_0000;
	localparam logic [7:0]  MAX_LINE_RST  = 8'd128;

	// Characters the size line parser cares about
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;

	typedef enum logic [2:0] {
		K_FRAME      = 3'd0,
		K_DATA       = 3'd1,
		K_DONE       = 3'd2,
		K_LONG_LINE  = 3'd3,
		K_LONG_CHUNK = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [31:0] max_chunk;
		logic [7:0]  max_line;
	} cfg_t;

	// {is_hex, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [7:0] off;
		off = 8'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			off = c - CH_ZERO;
			return {1'b1, off[3:0]};
		end
		if (c >= CH_LC_A && c <= CH_LC_F) begin
			off = c - CH_LC_A + 8'd10;
			return {1'b1, off[3:0]};
		end
		if (c >= CH_UC_A && c <= CH_UC_F) begin
			off = c - CH_UC_A + 8'd10;
			return {1'b1, off[3:0]};
		end
		return 5'd0;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/hcbd_parser.sv]
// Framing state machine: size line parse, data count, trailer skip.
// Depends on hcbd_pkg.
`default_nettype none

module hcbd_parser #(
	parameter int COUNT_WIDTH = hcbd_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       byte_in,
	input  wire hcbd_pkg::cfg_t   cfg,
	output hcbd_pkg::result_t     res
);

	localparam int ACC_W  = COUNT_WIDTH + 1;
	localparam int WIDE_W = COUNT_WIDTH + 5;
	localparam int CMP_W  = (ACC_W > 32) ? ACC_W : 32;
	localparam logic [WIDE_W-1:0] ACC_LIMIT = {{4{1'b0}}, 1'b1, {COUNT_WIDTH{1'b0}}};

	typedef enum logic [2:0] {
		PH_LINE,
		PH_DATA,
		PH_SKIP,
		PH_DONE,
		PH_ERR_LINE,
		PH_ERR_CHUNK
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] left_q, left_d;
	logic [ACC_W-1:0]       acc_q, acc_d;
	logic [7:0]             line_cnt_q, line_cnt_d;
	logic                   digits_q, digits_d;
	logic                   ended_q, ended_d;
	logic                   minus_q, minus_d;
	logic                   cr_q, cr_d;
	logic [1:0]             skip_q, skip_d;

	logic [4:0]        hex;
	logic [WIDE_W-1:0] acc_wide;
	logic              too_big;
	logic [1:0]        skip_n;

	assign hex      = hcbd_pkg::hex_decode(byte_in);
	assign acc_wide = {acc_q, 4'b0000} + WIDE_W'(hex[3:0]);
	assign too_big  = acc_q[COUNT_WIDTH] ||
		(CMP_W'(acc_q) > CMP_W'(cfg.max_chunk));
	assign skip_n   = (skip_q != 2'd0) ? skip_q - 2'd1 : 2'd0;

	always_comb begin
		phase_d    = phase_q;
		left_d     = left_q;
		acc_d      = acc_q;
		line_cnt_d = line_cnt_q;
		digits_d   = digits_q;
		ended_d    = ended_q;
		minus_d    = minus_q;
		cr_d       = cr_q;
		skip_d     = skip_q;
		res        = '{kind: hcbd_pkg::K_FRAME, data: 8'd0, last: 1'b0};
		unique case (phase_q)
			PH_LINE: begin
				if (line_cnt_q >= cfg.max_line) begin
					phase_d  = PH_ERR_LINE;
					res.kind = hcbd_pkg::K_LONG_LINE;
				end else begin
					line_cnt_d = line_cnt_q + 8'd1;
					if (byte_in == hcbd_pkg::CH_LF && cr_q) begin
						if (minus_q || !digits_q || acc_q == '0) begin
							phase_d  = PH_DONE;
							res.kind = hcbd_pkg::K_DONE;
						end else if (too_big) begin
							phase_d  = PH_ERR_CHUNK;
							res.kind = hcbd_pkg::K_LONG_CHUNK;
						end else begin
							left_d     = acc_q[COUNT_WIDTH-1:0];
							phase_d    = PH_DATA;
							acc_d      = '0;
							line_cnt_d = 8'd0;
							digits_d   = 1'b0;
							ended_d    = 1'b0;
							minus_d    = 1'b0;
							cr_d       = 1'b0;
						end
					end else begin
						cr_d = (byte_in == hcbd_pkg::CH_CR);
						if (!ended_q) begin
							priority if (hex[4]) begin
								// saturate at 2^COUNT_WIDTH
								acc_d = (acc_wide > ACC_LIMIT) ? ACC_LIMIT[ACC_W-1:0]
									: acc_wide[ACC_W-1:0];
								digits_d = 1'b1;
							end else if (byte_in == hcbd_pkg::CH_MINUS &&
									line_cnt_q == 8'd0) begin
								minus_d = 1'b1;
							end else begin
								ended_d = 1'b1;
							end
						end
					end
				end
			end
			PH_DATA: begin
				res.kind = hcbd_pkg::K_DATA;
				res.data = byte_in;
				left_d   = left_q - COUNT_WIDTH'(1);
				if (left_q == COUNT_WIDTH'(1)) begin
					res.last = 1'b1;
					phase_d  = PH_SKIP;
					skip_d   = 2'd2;
				end
			end
			PH_SKIP: begin
				skip_d = skip_n;
				if (skip_n == 2'd0) begin
					phase_d    = PH_LINE;
					acc_d      = '0;
					line_cnt_d = 8'd0;
					digits_d   = 1'b0;
					ended_d    = 1'b0;
					minus_d    = 1'b0;
					cr_d       = 1'b0;
				end
			end
			PH_ERR_LINE:  res.kind = hcbd_pkg::K_LONG_LINE;
			PH_ERR_CHUNK: res.kind = hcbd_pkg::K_LONG_CHUNK;
			default: begin
				phase_d  = PH_DONE;
				res.kind = hcbd_pkg::K_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LINE;
			left_q     <= '0;
			acc_q      <= '0;
			line_cnt_q <= 8'd0;
			digits_q   <= 1'b0;
			ended_q    <= 1'b0;
			minus_q    <= 1'b0;
			cr_q       <= 1'b0;
			skip_q     <= 2'd0;
		end else if (step) begin
			phase_q    <= phase_d;
			left_q     <= left_d;
			acc_q      <= acc_d;
			line_cnt_q <= line_cnt_d;
			digits_q   <= digits_d;
			ended_q    <= ended_d;
			minus_q    <= minus_d;
			cr_q       <= cr_d;
			skip_q     <= skip_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/hcbd_out_reg.sv]
// Result register in front of the output channel.
// Depends on hcbd_pkg.
`default_nettype none

module hcbd_out_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire hcbd_pkg::result_t  res_in,
	input  wire logic               ready,
	output logic                    valid,
	output hcbd_pkg::result_t       res_out
);

	logic              valid_q;
	hcbd_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign valid   = valid_q;
	assign res_out = res_q;

endmodule

`default_nettype wire

[hw/rtl/http_chunked_body_decoder.sv]
// Top level of the HTTP chunked body decoder: input register, parser, result register.
// Depends on hcbd_pkg, hcbd_parser, hcbd_out_reg and the assertion macro header.
`default_nettype none

//  channel | handshake              | payload
//  --------+------------------------+------------------------------
//  in      | in_valid / in_ready    | in_byte
//  out     | out_valid / out_ready  | kind, out_byte, chunk_last
//  cfg     | cfg_wr_en (no stall)   | cfg_index, cfg_wr_data
//
// One beat in gives one beat out, through the input register and then the result register.
// Sustains one byte per cycle while out_ready stays high; the parser state update is the only loop.
// Reset puts the parser at the start of a size line and loads the register defaults.
// A stalled output holds its beat; the input register then fills and in_ready drops.

`include "http_chunked_body_decoder_macros.svh"

module http_chunked_body_decoder #(
	parameter int COUNT_WIDTH = hcbd_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    in_byte,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [2:0]                         kind,
	output logic [7:0]                         out_byte,
	output logic                               chunk_last,
	input  wire logic                          cfg_wr_en,
	input  wire logic [hcbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [hcbd_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

	hcbd_pkg::cfg_t    cfg_q;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              advance;
	hcbd_pkg::result_t res_s1;
	hcbd_pkg::result_t res_s2;

	// Configuration registers: the user must write them only while idle; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_chunk <= hcbd_pkg::MAX_CHUNK_RST;
			cfg_q.max_line  <= hcbd_pkg::MAX_LINE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				hcbd_pkg::REG_MAX_CHUNK: cfg_q.max_chunk <= cfg_wr_data;
				hcbd_pkg::REG_MAX_LINE:  cfg_q.max_line  <= cfg_wr_data[7:0];
			endcase
		end
	end

	// Input stage: the byte moves on whenever the result register has room.
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	// Parser steps once per byte leaving the input stage.
	hcbd_parser #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_in (byte_s1),
		.cfg     (cfg_q),
		.res     (res_s1)
	);

	hcbd_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance),
		.res_in  (res_s1),
		.ready   (out_ready),
		.valid   (out_valid),
		.res_out (res_s2)
	);

	assign kind       = res_s2.kind;
	assign out_byte   = res_s2.data;
	assign chunk_last = res_s2.last;

	// Only data beats carry a byte or a chunk end mark.
	`HCBD_ASSERT_NOW(a_byte_only_data, out_valid && kind != hcbd_pkg::K_DATA, out_byte == 8'd0)
	`HCBD_ASSERT_NOW(a_last_only_data, out_valid && chunk_last, kind == hcbd_pkg::K_DATA)
	// A full input stage behind a stalled result must hold off new beats.
	`HCBD_ASSERT_NOW(a_no_overrun, valid_s1 && out_valid && !out_ready, !in_ready)
	// A loaded result is presented on the next cycle.
	`HCBD_ASSERT_NEXT(a_load_shows, advance, out_valid)

endmodule

`default_nettype wire

[verif/tb_http_chunked_body_decoder.sv]
// Self-checking testbench for the HTTP chunked body decoder: drives body bytes,
// predicts every result beat in place and compares them with what the block returns.
// Depends on hcbd_pkg and the http_chunked_body_decoder RTL.
`default_nettype none

module tb_http_chunked_body_decoder;

	// Phases of the local parser copy
	typedef enum logic [2:0] {
		P_LINE,
		P_DATA,
		P_SKIP,
		P_DONE,
		P_ERR_LINE,
		P_ERR_CHUNK
	} parse_phase_t;

	// How the single body of the run is closed; the decoder never leaves these
	// states, so only one of them can be reached per run (the seed picks it).
	typedef enum logic [2:0] {
		END_ZERO,
		END_NEGATIVE,
		END_NO_DIGITS,
		END_LONG_LINE,
		END_LONG_CHUNK
	} body_end_t;

	localparam logic [32:0] ACC_CAP = 33'h1_0000_0000;  // accumulator saturation point

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           in_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic [2:0]           kind;
	logic [7:0]           out_byte;
	logic                 chunk_last;
	logic                 cfg_wr_en;
	logic [hcbd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [hcbd_pkg::CFG_DATA_W-1:0] cfg_wr_data;

	// Traffic shaping, percent of cycles spent idle on each side
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned long_hold_cycles;   // nonzero asks the sink for one long stall

	int unsigned bytes_sent;
	int unsigned chunks_sent;
	int unsigned beats_checked;
	int unsigned fail_count;
	int unsigned input_stall_cycles;
	body_end_t   end_reason;

	hcbd_pkg::result_t expected_beats[$];
	hcbd_pkg::result_t want_beat;

	// Local copy of the parser state and the two limit registers
	parse_phase_t ph;
	logic [31:0]  remaining;
	logic [32:0]  acc;
	logic [7:0]   line_len;
	bit           got_digits;
	bit           digits_done;
	bit           negative;
	bit           after_cr;
	logic [1:0]   skip_cnt;
	logic [31:0]  lim_chunk;
	logic [7:0]   lim_line;

	http_chunked_body_decoder uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.out_byte    (out_byte),
		.chunk_last  (chunk_last),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop; a healthy run needs only a small fraction of this.
	initial begin
		#400000;
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------

	// Hex digit value, -1 for anything else
	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= hcbd_pkg::CH_ZERO && c <= hcbd_pkg::CH_NINE)
			return int'(c - hcbd_pkg::CH_ZERO);
		if (c >= hcbd_pkg::CH_LC_A && c <= hcbd_pkg::CH_LC_F)
			return int'(c - hcbd_pkg::CH_LC_A) + 10;
		if (c >= hcbd_pkg::CH_UC_A && c <= hcbd_pkg::CH_UC_F)
			return int'(c - hcbd_pkg::CH_UC_A) + 10;
		return -1;
	endfunction

	function automatic void clear_line();
		acc = '0;
		line_len = '0;
		got_digits = 1'b0;
		digits_done = 1'b0;
		negative = 1'b0;
		after_cr = 1'b0;
	endfunction

	// Advance the model by one body byte and return the beat it must produce.
	function automatic hcbd_pkg::result_t decode_byte(input logic [7:0] c);
		hcbd_pkg::result_t r;
		int nib;
		logic [63:0] grown;
		r.kind = hcbd_pkg::K_FRAME;
		r.data = 8'h00;
		r.last = 1'b0;
		case (ph)
			P_LINE: begin
				if (line_len >= lim_line) begin
					// line limit counts CR LF too; one byte past it is fatal
					ph = P_ERR_LINE;
					r.kind = hcbd_pkg::K_LONG_LINE;
				end else begin
					line_len++;
					if (c == hcbd_pkg::CH_LF && after_cr) begin
						if (negative || !got_digits || acc == 0) begin
							ph = P_DONE;
							r.kind = hcbd_pkg::K_DONE;
						end else if (acc > {1'b0, lim_chunk}) begin
							// also catches a saturated accumulator, since the limit
							// is at most 2^32-1
							ph = P_ERR_CHUNK;
							r.kind = hcbd_pkg::K_LONG_CHUNK;
						end else begin
							remaining = acc[31:0];
							ph = P_DATA;
							clear_line();
						end
					end else begin
						after_cr = (c == hcbd_pkg::CH_CR);
						if (!digits_done) begin
							nib = hex_nibble(c);
							if (nib >= 0) begin
								grown = {31'b0, acc} * 64'd16 + 64'(nib);
								acc = (grown > 64'(ACC_CAP)) ? ACC_CAP : grown[32:0];
								got_digits = 1'b1;
							end else if (c == hcbd_pkg::CH_MINUS && line_len == 8'd1) begin
								negative = 1'b1;
							end else begin
								digits_done = 1'b1;
							end
						end
					end
				end
			end
			P_DATA: begin
				r.kind = hcbd_pkg::K_DATA;
				r.data = c;
				if (remaining != 0)
					remaining--;
				if (remaining == 0) begin
					r.last = 1'b1;
					ph = P_SKIP;
					skip_cnt = 2'd2;
				end
			end
			P_SKIP: begin
				// trailing CR LF after data, contents not checked
				if (skip_cnt != 0)
					skip_cnt--;
				if (skip_cnt == 0) begin
					ph = P_LINE;
					clear_line();
				end
			end
			P_ERR_LINE:  r.kind = hcbd_pkg::K_LONG_LINE;
			P_ERR_CHUNK: r.kind = hcbd_pkg::K_LONG_CHUNK;
			default: begin
				ph = P_DONE;
				r.kind = hcbd_pkg::K_DONE;
			end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				note_failure($sformatf("beat with nothing pending: kind=%0d byte=%02h last=%0b",
					kind, out_byte, chunk_last));
			end else begin
				want_beat = expected_beats.pop_front();
				beats_checked++;
				if (kind !== want_beat.kind || out_byte !== want_beat.data ||
						chunk_last !== want_beat.last)
					note_failure($sformatf({"beat %0d: want kind=%0d byte=%02h last=%0b,",
						" got kind=%0d byte=%02h last=%0b"}, beats_checked,
						want_beat.kind, want_beat.data, want_beat.last,
						kind, out_byte, chunk_last));
			end
		end
	end

	// Input back-pressure seen by the source
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_ready)
			input_stall_cycles++;
	end

	// Result sink: random ready, or one long stall when asked
	initial begin : result_sink
		int unsigned n;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_cycles != 0) begin
				n = long_hold_cycles;
				long_hold_cycles = 0;
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// One beat on the input channel; the model is advanced at acceptance.
	// Each cycle before the beat is offered is idle with the sender's odds.
	task automatic send_byte(input logic [7:0] b);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (!in_ready);
		expected_beats.insert(expected_beats.size(), decode_byte(b));
		bytes_sent++;
	endtask

	// Drop valid right after the last accepted beat, then wait for every pending result.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_beats.size() != 0);
	endtask

	task automatic write_reg(input logic [hcbd_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == hcbd_pkg::REG_MAX_CHUNK)
			lim_chunk = v;
		else
			lim_line = v[7:0];
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 4'd10)
			return hcbd_pkg::CH_ZERO + {4'h0, n};
		return (upper ? hcbd_pkg::CH_UC_A : hcbd_pkg::CH_LC_A) + {4'h0, n} - 8'd10;
	endfunction

	// Random hex digit of random case
	function automatic logic [7:0] rand_hex_char();
		return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
	endfunction

	function automatic int unsigned nibble_count(input logic [31:0] v);
		int unsigned n;
		n = 1;
		while (n < 8 && (v >> (4 * n)) != 0)
			n++;
		return n;
	endfunction

	// Extension filler: anything, but never an LF right after a CR
	function automatic logic [7:0] ext_byte(input logic [7:0] prev);
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (prev == hcbd_pkg::CH_CR && b == hcbd_pkg::CH_LF)
			b = "~";
		return b;
	endfunction

	task automatic send_hex(input logic [31:0] v, input int unsigned ndig);
		for (int i = int'(ndig) - 1; i >= 0; i--)
			send_byte(hex_char(v[4 * i +: 4], 1'($urandom_range(0, 1))));
	endtask

	// Mostly small chunks, now and then a few hundred bytes, kept legal for
	// the current limits (size and number of digits that fit in a line).
	function automatic int unsigned pick_size();
		int unsigned s;
		int unsigned maxd;
		s = ($urandom_range(99) < 90) ? $urandom_range(1, 16) : $urandom_range(17, 300);
		if (lim_chunk <= 300 && $urandom_range(9) == 0)
			s = lim_chunk;
		if (s > lim_chunk)
			s = lim_chunk;
		maxd = lim_line - 2;
		if (maxd < 3 && s > (1 << (4 * maxd)) - 1)
			s = (1 << (4 * maxd)) - 1;
		return s;
	endfunction

	// Extra size-line bytes wanted: usually none or a few, rarely a full line
	function automatic int unsigned pad_request();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50)
			return 0;
		if (r < 97)
			return $urandom_range(1, 8);
		return 255;
	endfunction

	// Well-formed chunk: optional leading zeros, mixed-case hex size, optional
	// extension text, CR LF, data, then two trailer bytes that are not checked.
	task automatic send_chunk(input int unsigned size, input int unsigned pad_req);
		int unsigned ndig;
		int unsigned room;
		int unsigned pad;
		int unsigned zeros;
		logic [7:0] b;
		logic [7:0] prev;
		ndig = nibble_count(size);
		room = (lim_line >= ndig + 2) ? lim_line - ndig - 2 : 0;
		pad = (pad_req < room) ? pad_req : room;
		zeros = (pad != 0) ? $urandom_range(0, pad) : 0;
		repeat (zeros) send_byte(hcbd_pkg::CH_ZERO);
		send_hex(size, ndig);
		prev = hcbd_pkg::CH_ZERO;
		for (int unsigned i = 0; i < pad - zeros; i++) begin
			if (i == 0) begin
				// first extension byte must end the digit run
				do b = 8'($urandom_range(0, 255)); while (hex_nibble(b) >= 0);
			end else begin
				b = ext_byte(prev);
			end
			send_byte(b);
			prev = b;
		end
		send_byte(hcbd_pkg::CH_CR);
		send_byte(hcbd_pkg::CH_LF);
		repeat (size) send_byte(8'($urandom_range(0, 255)));
		if ($urandom_range(1)) begin
			send_byte(hcbd_pkg::CH_CR);
			send_byte(hcbd_pkg::CH_LF);
		end else begin
			repeat (2) send_byte(8'($urandom_range(0, 255)));
		end
		chunks_sent++;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hand-built chunks under reset limits: extreme data values, padded size,
	// extension with a hex letter, a CR not followed by LF, a lone LF,
	// an LF as payload and a junk trailer.
	task automatic test_directed_framing();
		send_byte("1");
		send_byte(hcbd_pkg::CH_CR);
		send_byte(hcbd_pkg::CH_LF);
		send_byte(8'h00);
		send_byte(hcbd_pkg::CH_CR);
		send_byte(hcbd_pkg::CH_LF);
		send_hex(32'h2, 4);
		send_byte(";");
		send_byte("e");
		send_byte(hcbd_pkg::CH_CR);
		send_byte("q");
		send_byte(hcbd_pkg::CH_LF);
		send_byte(hcbd_pkg::CH_CR);
		send_byte(hcbd_pkg::CH_LF);
		send_byte(8'hFF);
		send_byte(hcbd_pkg::CH_LF);
		send_byte("x");
		send_byte("y");
		chunks_sent += 2;
	endtask

	// Smallest limits: one-byte chunks and three-byte size lines
	task automatic test_tight_limits();
		settle();
		write_reg(hcbd_pkg::REG_MAX_CHUNK, 32'd1);
		write_reg(hcbd_pkg::REG_MAX_LINE, 32'd3);
		repeat (12) send_chunk(pick_size(), pad_request());
	endtask

	// Largest limits: full 255-byte size lines alongside normal ones
	task automatic test_wide_limits();
		settle();
		write_reg(hcbd_pkg::REG_MAX_CHUNK, 32'hFFFF_FFFF);
		write_reg(hcbd_pkg::REG_MAX_LINE, 32'd255);
		send_chunk(pick_size(), 255);
		send_chunk(pick_size(), pad_request());
		send_chunk(pick_size(), 255);
		send_chunk(pick_size(), pad_request());
	endtask

	// Three segments, one per idle mix, with fresh limits every ~150 bytes
	task automatic test_random_bodies();
		int unsigned target;
		int unsigned last_cfg;
		logic [31:0] c;
		for (int seg = 0; seg < 3; seg++) begin
			send_idle_pct = (seg == 0) ? 14 : (seg == 1) ? 82 : 0;
			recv_idle_pct = (seg == 0) ? 82 : (seg == 1) ? 14 : 0;
			target = bytes_sent + 320;
			last_cfg = bytes_sent;
			while (bytes_sent < target) begin
				if (bytes_sent - last_cfg >= 150) begin
					settle();
					case ($urandom_range(3))
						0: c = $urandom_range(1, 64);
						1: c = hcbd_pkg::MAX_CHUNK_RST;
						2: c = $urandom;
						default: c = 32'hFFFF_FFFF;
					endcase
					if (c == 0)
						c = 1;
					write_reg(hcbd_pkg::REG_MAX_CHUNK, c);
					case ($urandom_range(2))
						0: write_reg(hcbd_pkg::REG_MAX_LINE, 32'd3);
						1: write_reg(hcbd_pkg::REG_MAX_LINE, 32'd255);
						default: write_reg(hcbd_pkg::REG_MAX_LINE, $urandom_range(3, 255));
					endcase
					last_cfg = bytes_sent;
				end
				send_chunk(pick_size(), pad_request());
			end
		end
	endtask

	// Long output stall while the source keeps pushing: the block must fill,
	// drop in_ready, and lose nothing.
	task automatic test_output_backpressure();
		settle();
		write_reg(hcbd_pkg::REG_MAX_CHUNK, hcbd_pkg::MAX_CHUNK_RST);
		write_reg(hcbd_pkg::REG_MAX_LINE, 32'd64);
		long_hold_cycles = 200;
		send_chunk(40, 0);
		send_chunk(40, pad_request());
	endtask

	// Close the body one of five ways, then confirm the end state holds.
	task automatic test_body_end();
		int unsigned n;
		logic [7:0] b;
		logic [7:0] prev;
		settle();
		end_reason = body_end_t'($urandom_range(0, 4));
		write_reg(hcbd_pkg::REG_MAX_LINE,
			(end_reason == END_LONG_LINE) ? $urandom_range(3, 40) : 255);
		if (end_reason == END_LONG_CHUNK)
			write_reg(hcbd_pkg::REG_MAX_CHUNK,
				$urandom_range(1) ? $urandom_range(1, 32'hFFFF) : 32'hFFFF_FFFF);
		case (end_reason)
			END_ZERO: begin
				repeat ($urandom_range(1, 3)) send_byte(hcbd_pkg::CH_ZERO);
				if ($urandom_range(1))
					send_byte(";");
			end
			END_NEGATIVE: begin
				// digits after the sign do not matter, zero or many
				send_byte(hcbd_pkg::CH_MINUS);
				repeat ($urandom_range(0, 4))
					send_byte(rand_hex_char());
			end
			END_NO_DIGITS: begin
				do b = 8'($urandom_range(0, 255));
				while (hex_nibble(b) >= 0 || b == hcbd_pkg::CH_MINUS ||
					b == hcbd_pkg::CH_CR || b == hcbd_pkg::CH_LF);
				send_byte(b);
				prev = b;
				repeat ($urandom_range(0, 5)) begin
					b = ext_byte(prev);
					send_byte(b);
					prev = b;
				end
			end
			END_LONG_LINE: begin
				// hex only, so the accumulator also saturates on longer limits
				n = lim_line + $urandom_range(1, 5);
				repeat (n) send_byte(rand_hex_char());
			end
			default: begin
				if (lim_chunk != 32'hFFFF_FFFF) begin
					send_hex(lim_chunk + 1, nibble_count(lim_chunk + 1));
				end else begin
					// more than 32 bits of size: saturates past 2^32-1
					send_byte("1");
					repeat ($urandom_range(8, 12))
						send_byte(rand_hex_char());
				end
			end
		endcase
		if (end_reason != END_LONG_LINE) begin
			send_byte(hcbd_pkg::CH_CR);
			send_byte(hcbd_pkg::CH_LF);
		end
		repeat (10) send_byte(8'($urandom_range(0, 255)));
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		int unsigned guard;
		int unsigned held;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_byte <= 8'h00;
		cfg_wr_en <= 1'b0;
		cfg_index <= hcbd_pkg::REG_MAX_CHUNK;
		cfg_wr_data <= '0;
		send_idle_pct = 14;
		recv_idle_pct = 82;
		long_hold_cycles = 0;
		bytes_sent = 0;
		chunks_sent = 0;
		beats_checked = 0;
		fail_count = 0;
		input_stall_cycles = 0;
		end_reason = END_ZERO;

		// model starts from the reset state and default limits
		ph = P_LINE;
		remaining = '0;
		skip_cnt = '0;
		clear_line();
		lim_chunk = hcbd_pkg::MAX_CHUNK_RST;
		lim_line = hcbd_pkg::MAX_LINE_RST;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_framing();
		test_tight_limits();
		test_wide_limits();
		test_random_bodies();
		held = input_stall_cycles;
		test_output_backpressure();
		held = input_stall_cycles - held;
		test_body_end();

		// drain, then a few quiet cycles to catch stray beats
		in_valid <= 1'b0;
		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (expected_beats.size() != 0 && guard < 20000);
		repeat (10) @(posedge clk);
		if (expected_beats.size() != 0)
			note_failure($sformatf("%0d expected beats never arrived", expected_beats.size()));

		$display("Covered %0d body bytes in %0d chunks over three idle mixes and limit changes;",
			bytes_sent, chunks_sent);
		$display("%0d beats compared, body closed by %s, input held off %0d cycles in long stall.",
			beats_checked, end_reason.name(), held);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

[http_chunked_body_decoder.f]
+incdir+hw/rtl
hw/rtl/hcbd_pkg.sv
hw/rtl/hcbd_parser.sv
hw/rtl/hcbd_out_reg.sv
hw/rtl/http_chunked_body_decoder.sv
verif/tb_http_chunked_body_decoder.sv
